@@ src/wcc_pkg.sv @@
// wcc_pkg: shared constants and types for the word cache controller
// no dependencies

package wcc_pkg;

	localparam int LINES = 32;
	localparam int LINE_W = $clog2(LINES);
	localparam int AGE_W = $clog2(LINES);
	localparam logic [AGE_W-1:0] AGE_TOP = AGE_W'(LINES - 1);

	// cells between chain registers, and the number of segments
	localparam int SEG_LEN = 8;
	localparam int SEGS = (LINES + SEG_LEN - 1) / SEG_LEN;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_FILL  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		K_READ   = 3'd0,
		K_DONE   = 3'd1,
		K_MREAD  = 3'd2,
		K_MWRITE = 3'd3,
		K_ERR    = 3'd4
	} kind_t;

	localparam logic CFG_MAPPING = 1'b0;
	localparam logic CFG_WRITE   = 1'b1;

	// token that travels down the cell chain
	typedef struct packed {
		logic             lookup;  // search pass
		logic [15:0]      address;
		logic             found;
		logic [LINE_W-1:0] hit_line;
		logic             inv_found;
		logic [LINE_W-1:0] inv_line;
		logic [AGE_W-1:0]  min_age;
		logic [LINE_W-1:0] min_line;
	} chain_t;

	// command broadcast to all cells for the update cycle
	typedef struct packed {
		logic              write_en;
		logic [LINE_W-1:0] line;
		logic [15:0]       tag;
		logic [15:0]       word;
		logic              valid;
		logic              dirty;
		logic              touch;
	} upd_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] word;
		logic        valid;
		logic        dirty;
		logic [AGE_W-1:0] age;
	} line_view_t;

endpackage

@@ src/wcc_if.sv @@
// wcc_if: valid/ready channel interfaces for the word cache controller
// no dependencies

interface wcc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] address;
	logic [15:0] data;
	logic        byte_word;
	modport source (output valid, opcode, address, data, byte_word, input ready);
	modport sink (input valid, opcode, address, data, byte_word, output ready);
endinterface

interface wcc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] address_out;
	logic [15:0] data_out;
	logic        size_out;
	logic        was_hit;
	logic        last;
	modport source (output valid, kind, address_out, data_out, size_out, was_hit, last,
		input ready);
	modport sink (input valid, kind, address_out, data_out, size_out, was_hit, last,
		output ready);
endinterface

@@ src/word_cache_controller.sv @@
// word_cache_controller: one-word-line cache, direct or associative, wb or wt
// depends on wcc_pkg, wcc_if, wcc_chain, wcc_cell
//
//  channel | dir | carries
//  --------+-----+-----------------------------------------------
//  req     | in  | opcode, address, data, byte_word
//  rsp     | out | kind, address_out, data_out, size_out, was_hit, last
//  cfg     | in  | cfg_we, cfg_index, cfg_data (mapping_mode, write_mode)
//
// each transfer walks a token through the cell row; the row is cut by a
// register every eight cells, and a search steps the token through each
// segment in turn, followed by a line update in the decide state and one
// output transfer per result
// reset clears valid, dirty and ages at once; no clearing pass
// a stalled output holds the block in its emit state; no input is taken then

module word_cache_controller (
	input  logic         clk,
	input  logic         arst_n,
	wcc_in_if.sink       req,
	wcc_out_if.source    rsp,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic         cfg_data
);

	localparam int SW = $clog2(wcc_pkg::SEGS + 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SEARCH = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_EMIT1  = 5'b01000,
		ST_EMIT2  = 5'b10000
	} state_t;

	state_t state_q;

	logic mapping_q, wmode_q;
	logic miss_pending_q;
	logic [15:0] pending_address_q;
	logic [wcc_pkg::LINE_W-1:0] pending_line_q;
	logic [31:0] hit_total_q, miss_total_q;

	// captured request
	logic [1:0]  op_q;
	logic [15:0] addr_q, data_q;
	logic        size_q;
	logic [SW-1:0] cnt_q;

	// queued results
	logic [2:0]  k1_q, k2_q;
	logic [15:0] a1_q, a2_q, d1_q, d2_q;
	logic        h1_q, h2_q;
	logic        two_q;
	logic        one_q;

	wcc_pkg::chain_t     head, tail;
	wcc_pkg::upd_t       upd;
	wcc_pkg::line_view_t vview;
	logic [wcc_pkg::LINE_W-1:0] sel;

	logic start;
	assign start = (state_q == ST_IDLE) && req.valid;
	assign req.ready = (state_q == ST_IDLE);

	always_comb begin
		head = '0;
		head.lookup  = 1'b1;
		head.address = addr_q;
	end

	// decide-cycle lookup outcome
	logic [wcc_pkg::LINE_W-1:0] dline, line;
	logic hit, err;
	assign dline = addr_q[wcc_pkg::LINE_W-1:0];

	always_comb begin
		priority if (!mapping_q) line = dline;
		else if (tail.found) line = tail.hit_line;
		else if (tail.inv_found) line = tail.inv_line;
		else line = tail.min_line;
	end

	assign sel = (op_q == wcc_pkg::OP_FILL) ? pending_line_q : line;
	assign hit = mapping_q ? tail.found : (vview.valid && vview.tag == addr_q);
	assign err = (op_q == wcc_pkg::OP_NONE) ||
		((op_q == wcc_pkg::OP_FILL) != miss_pending_q);

	wcc_chain u_chain (
		.clk(clk), .arst_n(arst_n),
		.head(head), .tail(tail),
		.upd(upd), .sel(sel), .sel_view(vview)
	);

	logic decide;
	logic wb;
	assign decide = (state_q == ST_DECIDE);
	assign wb = !hit && vview.valid && vview.dirty;

	// line update issued in the decide cycle
	always_comb begin
		upd = '0;
		upd.line = sel;
		if (decide && !err) begin
			unique case (op_q)
				wcc_pkg::OP_FILL: begin
					upd.write_en = 1'b1;
					upd.tag = pending_address_q;
					upd.word = data_q;
					upd.valid = 1'b1;
					upd.touch = mapping_q;
				end
				wcc_pkg::OP_READ: begin
					upd.tag = vview.tag;
					upd.word = vview.word;
					if (hit) begin
						upd.touch = mapping_q;
					end else begin
						upd.write_en = 1'b1; // invalidate victim
					end
				end
				default: begin
					upd.write_en = 1'b1;
					upd.tag = addr_q;
					upd.word = data_q;
					upd.valid = 1'b1;
					upd.dirty = !wmode_q;
					upd.touch = mapping_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapping_q <= 1'b0;
			wmode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wcc_pkg::CFG_MAPPING: mapping_q <= cfg_data;
				wcc_pkg::CFG_WRITE:   wmode_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q <= req.opcode;
			addr_q <= req.address;
			data_q <= req.data;
			size_q <= req.byte_word;
		end
	end

	// result queue filled at decide
	always_ff @(posedge clk) begin
		if (decide) begin
			a2_q <= '0; d2_q <= '0; h2_q <= 1'b0; k2_q <= wcc_pkg::K_ERR;
			if (err) begin
				k1_q <= wcc_pkg::K_ERR; a1_q <= addr_q; d1_q <= '0; h1_q <= 1'b0;
			end else if (op_q == wcc_pkg::OP_FILL) begin
				k1_q <= wcc_pkg::K_READ; a1_q <= pending_address_q;
				d1_q <= data_q; h1_q <= 1'b0;
			end else begin
				// second result is the primary one when a write-back leads
				k1_q <= wcc_pkg::K_MWRITE; a1_q <= vview.tag; d1_q <= vview.word;
				h1_q <= 1'b0;
				if (op_q == wcc_pkg::OP_READ) begin
					if (hit) begin
						k2_q <= wcc_pkg::K_READ; a2_q <= addr_q; d2_q <= vview.word;
						h2_q <= 1'b1;
					end else begin
						k2_q <= wcc_pkg::K_MREAD; a2_q <= addr_q;
					end
				end else if (wmode_q) begin
					k2_q <= wcc_pkg::K_MWRITE; a2_q <= addr_q; d2_q <= data_q; h2_q <= hit;
				end else begin
					k2_q <= wcc_pkg::K_DONE; a2_q <= addr_q; h2_q <= hit;
				end
			end
		end
	end

	// single-result items keep their only result in slot one
	logic single, one_only;
	assign single = err || op_q == wcc_pkg::OP_FILL;
	assign one_only = one_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			two_q <= 1'b0;
			one_q <= 1'b0;
			miss_pending_q <= 1'b0;
			pending_address_q <= '0;
			pending_line_q <= '0;
			hit_total_q <= '0;
			miss_total_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (start) begin
					state_q <= ST_SEARCH;
					cnt_q <= '0;
				end
				ST_SEARCH: begin
					if (cnt_q == SW'(wcc_pkg::SEGS - 1)) state_q <= ST_DECIDE;
					else cnt_q <= cnt_q + 1'b1;
				end
				ST_DECIDE: begin
					state_q <= ST_EMIT1;
					one_q <= single;
					two_q <= !single && wb;
					if (!err) begin
						if (op_q == wcc_pkg::OP_FILL) begin
							miss_pending_q <= 1'b0;
						end else begin
							if (hit) hit_total_q <= hit_total_q + 1'b1;
							else miss_total_q <= miss_total_q + 1'b1;
							if (op_q == wcc_pkg::OP_READ && !hit) begin
								miss_pending_q <= 1'b1;
								pending_address_q <= addr_q;
								pending_line_q <= line;
							end
						end
					end
				end
				ST_EMIT1: if (rsp.ready) begin
					state_q <= two_q ? ST_EMIT2 : ST_IDLE;
				end
				ST_EMIT2: if (rsp.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// emit1 shows slot one when a write-back leads or the item has one result;
	// otherwise the primary result in slot two goes out directly
	logic show2;
	assign show2 = (state_q == ST_EMIT2) ||
		(state_q == ST_EMIT1 && !one_only && !two_q);

	assign rsp.valid = (state_q == ST_EMIT1) || (state_q == ST_EMIT2);
	assign rsp.kind = show2 ? k2_q : k1_q;
	assign rsp.address_out = show2 ? a2_q : a1_q;
	assign rsp.data_out = show2 ? d2_q : d1_q;
	assign rsp.was_hit = show2 ? h2_q : h1_q;
	assign rsp.size_out = size_q;
	assign rsp.last = show2 || one_only;

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && rsp.last |=> req.ready)
		else $error("block not idle after last transfer");
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !rsp.valid)
		else $error("result shown before search");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state not one-hot");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind == wcc_pkg::K_MREAD |=> miss_pending_q)
		else $error("memory read without pending miss");

endmodule

@@ src/wcc_cell.sv @@
// wcc_cell: one cache line with its compare and victim-selection step
// depends on wcc_pkg

module wcc_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [wcc_pkg::LINE_W-1:0]  my_index,
	input  wcc_pkg::chain_t             chain_in,
	output wcc_pkg::chain_t             chain_out,
	input  wcc_pkg::upd_t               upd,
	output wcc_pkg::line_view_t         view
);

	logic [15:0] tag_q;
	logic [15:0] word_q;
	logic        valid_q;
	logic        dirty_q;
	logic [wcc_pkg::AGE_W-1:0] age_q;
	logic        mine;

	assign mine = (upd.line == my_index);

	always_ff @(posedge clk) begin
		if (upd.write_en && mine) begin
			tag_q  <= upd.tag;
			word_q <= upd.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
			age_q   <= '0;
		end else begin
			if (upd.write_en && mine) begin
				valid_q <= upd.valid;
				dirty_q <= upd.dirty;
			end
			if (upd.touch) begin
				if (mine) age_q <= wcc_pkg::AGE_TOP;
				else if (age_q != '0) age_q <= age_q - 1'b1;
			end
		end
	end

	// search step: first hit, first invalid, lowest age (first on tie)
	always_comb begin
		chain_out = chain_in;
		if (chain_in.lookup) begin
			if (!chain_in.found && valid_q && tag_q == chain_in.address) begin
				chain_out.found    = 1'b1;
				chain_out.hit_line = my_index;
			end
			if (!chain_in.inv_found && !valid_q) begin
				chain_out.inv_found = 1'b1;
				chain_out.inv_line  = my_index;
			end
			if (my_index == '0 || age_q < chain_in.min_age) begin
				chain_out.min_age  = age_q;
				chain_out.min_line = my_index;
			end
		end
	end

	assign view = '{tag: tag_q, word: word_q, valid: valid_q, dirty: dirty_q, age: age_q};

endmodule

@@ src/wcc_chain.sv @@
// wcc_chain: row of line cells, registered every eight cells
// depends on wcc_pkg, wcc_cell

module wcc_chain (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wcc_pkg::chain_t      head,
	output wcc_pkg::chain_t      tail,
	input  wcc_pkg::upd_t        upd,
	input  logic [wcc_pkg::LINE_W-1:0] sel,
	output wcc_pkg::line_view_t  sel_view
);

	wcc_pkg::chain_t     link [wcc_pkg::LINES+1];
	wcc_pkg::chain_t     cin  [wcc_pkg::LINES];
	wcc_pkg::chain_t     seg_q [wcc_pkg::LINES];
	wcc_pkg::line_view_t views [wcc_pkg::LINES];

	assign link[0] = head;

	for (genvar i = 0; i < wcc_pkg::LINES; i++) begin : g_cell
		// a register cuts the chain at each segment boundary
		if (i % wcc_pkg::SEG_LEN == 0 && i != 0) begin : g_cut
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) seg_q[i] <= '0;
				else seg_q[i] <= link[i];
			end
			assign cin[i] = seg_q[i];
		end else begin : g_pass
			assign seg_q[i] = '0;
			assign cin[i] = link[i];
		end
		wcc_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.my_index(wcc_pkg::LINE_W'(i)),
			.chain_in(cin[i]), .chain_out(link[i+1]),
			.upd(upd), .view(views[i])
		);
	end

	assign tail = link[wcc_pkg::LINES];
	assign sel_view = views[sel];

endmodule
